// ===== hw/rtl/mm_pkg.sv =====
// Shared types, constants and helper functions of the matrix multiply block.
package mm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int FRAC_BITS = 16;

    localparam int DIM_W   = 3;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int VAL_W   = 32;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int ACC_W   = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Item kinds.
    localparam logic [1:0] KIND_WR_A    = 2'd0;
    localparam logic [1:0] KIND_WR_B    = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]              kind;
        logic [DIM_W-1:0]        row;
        logic [DIM_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [DIM_W-1:0]        out_row;
        logic [DIM_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd_en;
        logic             acc_clr;
        logic             emit;
        logic             last;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] k;
    } t_dp_cmd;

    // A register value of zero acts as one; values beyond MAX_DIM act as MAX_DIM.
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] res;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            res = CFG_W'(MAX_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [DIM_W-1:0] r,
                                                    input logic [DIM_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_DIM + int'(c));
    endfunction

    function automatic logic in_store(input logic [DIM_W-1:0] r,
                                      input logic [DIM_W-1:0] c);
        return (int'(r) < MAX_DIM) && (int'(c) < MAX_DIM);
    endfunction

    // Floor shift by the fraction width, then clamp to the signed 32-bit range.
    function automatic logic signed [VAL_W-1:0] sat_q(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        logic                    fits;
        logic signed [VAL_W-1:0] res;
        sh   = acc >>> FRAC_BITS;
        fits = (sh[ACC_W-1:VAL_W-1] == '0) || (sh[ACC_W-1:VAL_W-1] == '1);
        if (fits) begin
            res = sh[VAL_W-1:0];
        end else if (sh[ACC_W-1]) begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/mm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/mm_ctrl.sv =====
// Controller: configuration registers, sequencing state machine and loop counters.
module mm_ctrl
    import mm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic [1:0]           i_kind,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_cfg_ready,
    output logic                 busy,
    output t_dp_cmd              o_cmd
);

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_rows_a, r_inner_dim, r_cols_b;
    logic [DIM_W-1:0] r_row, r_col, r_k;
    logic [DIM_W-1:0] last_row, last_col, last_k;
    logic             accept;
    logic             k_done;
    logic             final_elem;

    assign last_row   = DIM_W'(eff_dim(r_rows_a) - CFG_W'(1));
    assign last_k     = DIM_W'(eff_dim(r_inner_dim) - CFG_W'(1));
    assign last_col   = DIM_W'(eff_dim(r_cols_b) - CFG_W'(1));
    assign accept     = start && (r_state == ST_IDLE);
    assign k_done     = (r_k == last_k);
    assign final_elem = (r_row == last_row) && (r_col == last_col);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DIM_RESET;
            r_inner_dim <= DIM_RESET;
            r_cols_b    <= DIM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROWS_A:    r_rows_a    <= i_cfg_data;
                REG_INNER_DIM: r_inner_dim <= i_cfg_data;
                REG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_row <= '0;
                    r_col <= '0;
                    r_k   <= '0;
                end
                ST_RUN: begin
                    r_k <= k_done ? '0 : r_k + DIM_W'(1);
                end
                ST_EMIT: begin
                    if (r_row == last_row) begin
                        r_row <= '0;
                        r_col <= r_col + DIM_W'(1);
                    end else begin
                        r_row <= r_row + DIM_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   n_state = (accept && (i_kind == KIND_COMPUTE)) ? ST_RUN : ST_IDLE;
            ST_RUN:    n_state = k_done ? ST_DRAIN1 : ST_RUN;
            ST_DRAIN1: n_state = ST_DRAIN2;
            ST_DRAIN2: n_state = ST_EMIT;
            ST_EMIT:   n_state = final_elem ? ST_IDLE : ST_RUN;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.row  = r_row;
        o_cmd.col  = r_col;
        o_cmd.k    = r_k;
        o_cmd.last = final_elem;
        busy       = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy          = 1'b0;
                o_cmd.wr_a    = accept && (i_kind == KIND_WR_A);
                o_cmd.wr_b    = accept && (i_kind == KIND_WR_B);
                o_cmd.acc_clr = 1'b1;
            end
            ST_RUN: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_EMIT: begin
                // The accumulator is captured into the output and cleared at the same edge.
                o_cmd.emit    = 1'b1;
                o_cmd.acc_clr = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/mm_dp.sv =====
// Datapath: element stores, multiply-accumulate pipeline and result register.
module mm_dp
    import mm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_dp_cmd   i_cmd,
    output t_out_item o_out,
    output logic      o_strobe
);

    logic [VAL_W-1:0]         a_rd, b_rd;
    logic                     wr_ok;
    logic                     r_v1, r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    t_out_item                r_out;
    logic                     r_strobe;

    assign wr_ok = in_store(i_in.row, i_in.col);

    mm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_a && wr_ok),
        .i_wr_addr (elem_addr(i_in.row, i_in.col)),
        .i_wr_data (i_in.value),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (elem_addr(i_cmd.row, i_cmd.k)),
        .o_rd_data (a_rd)
    );

    mm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_b && wr_ok),
        .i_wr_addr (elem_addr(i_in.row, i_in.col)),
        .i_wr_data (i_in.value),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (elem_addr(i_cmd.k, i_cmd.col)),
        .o_rd_data (b_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v1     <= i_cmd.rd_en;
            r_v2     <= r_v1;
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= $signed(a_rd) * $signed(b_rd);
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.emit) begin
            r_out.out_row   <= i_cmd.row;
            r_out.out_col   <= i_cmd.col;
            r_out.out_value <= sat_q(r_acc);
            r_out.last      <= i_cmd.last;
        end
    end

    assign o_out    = r_out;
    assign o_strobe = r_strobe;

endmodule

// ===== hw/rtl/matrix_multiply.sv =====
// Matrix multiply block, top level: controller and datapath.
//
// Loads of A or B elements are taken while idle and leave busy low. A compute item
// keeps busy high until its last element is handed off: the product elements
// come out column by column, each after inner_dim products from one shared 32x32
// multiply-accumulate fed by a single read port on each store, then the pipeline
// drains (ST_DRAIN1, ST_DRAIN2) and the result is handed off (ST_EMIT). Each result
// is on o_out for one cycle with o_strobe high and cannot be held off; o_out.last
// marks the final element. Dimension registers may only be written while busy is low.
module matrix_multiply
    import mm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_in,
    output t_out_item            o_out,
    output logic                 o_strobe,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd cmd;

    mm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_kind      (i_in.kind),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .busy        (busy),
        .o_cmd       (cmd)
    );

    mm_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_out    (o_out),
        .o_strobe (o_strobe)
    );

endmodule

// ===== test/matrix_multiply_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the matrix multiply block with a built-in product predictor.
module matrix_multiply_tb
    import mm_pkg::*;
();

    localparam logic [1:0]           KIND_NONE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
    localparam int                   N_ITEMS    = 370;
    localparam int                   IDLE_LIMIT = 4000;
    localparam int                   SETTLE     = 6;
    localparam int                   DRAIN      = 20;
    localparam logic signed [69:0]   SAT_MAX    = 70'sd2147483647;
    localparam logic signed [69:0]   SAT_MIN    = -70'sd2147483648;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in_item             i_in;
    t_out_item            o_out;
    logic                 o_strobe;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    matrix_multiply dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_strobe    (o_strobe),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Directed stimulus: either a register write or an input transaction.
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        t_in_item             req;
        bit                   has_exp;
        logic [VAL_W-1:0]     exp_val;
    } t_step;

    t_step steps[$];

    // Predictor state: both operand stores, their load marks and the dimension registers.
    logic signed [VAL_W-1:0] mat_a [DEPTH];
    logic signed [VAL_W-1:0] mat_b [DEPTH];
    bit                      a_loaded [DEPTH];
    bit                      b_loaded [DEPTH];
    logic [CFG_W-1:0]        reg_rows;
    logic [CFG_W-1:0]        reg_inner;
    logic [CFG_W-1:0]        reg_cols;

    t_out_item prod_queue[$];
    int        errors      = 0;
    int        items_sent  = 0;
    int        calm_left   = 0;

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        t_step s;
        s = '{default: '0};
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        steps = {steps, s};
    endfunction

    function automatic void add_item(logic [1:0] kind, int row, int col,
                                     logic [VAL_W-1:0] value, bit has_exp,
                                     logic [VAL_W-1:0] exp_val);
        t_step s;
        s = '{default: '0};
        s.req.kind  = kind;
        s.req.row   = DIM_W'(row);
        s.req.col   = DIM_W'(col);
        s.req.value = value;
        s.has_exp   = has_exp;
        s.exp_val   = exp_val;
        steps = {steps, s};
    endfunction

    // Register value as the block uses it: zero acts as one, large values clamp.
    function automatic int span(logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // Exact dot product, floor shift by the fraction width, then clamp to 32 bits.
    function automatic logic signed [VAL_W-1:0] element_sum(int r, int c, int n);
        logic signed [69:0] acc;
        logic signed [69:0] sh;
        logic signed [63:0] pa;
        logic signed [63:0] pb;
        acc = '0;
        for (int k = 0; k < n; k++) begin
            pa = mat_a[r * MAX_DIM + k];
            pb = mat_b[k * MAX_DIM + c];
            acc = acc + pa * pb;
        end
        sh = acc >>> FRAC_BITS;
        if (sh > SAT_MAX) return 32'h7FFF_FFFF;
        if (sh < SAT_MIN) return 32'h8000_0000;
        return sh[VAL_W-1:0];
    endfunction

    function automatic void apply_item(t_in_item it, bit has_exp, logic [VAL_W-1:0] exp_val);
        int        nr;
        int        nk;
        int        nc;
        int        idx;
        t_out_item e;
        idx = int'(it.row) * MAX_DIM + int'(it.col);
        case (it.kind)
            KIND_WR_A: begin
                mat_a[idx]    = it.value;
                a_loaded[idx] = 1'b1;
            end
            KIND_WR_B: begin
                mat_b[idx]    = it.value;
                b_loaded[idx] = 1'b1;
            end
            KIND_COMPUTE: begin
                if (has_exp) begin
                    // Typed rows run with all dimensions at one.
                    e.out_row   = '0;
                    e.out_col   = '0;
                    e.out_value = exp_val;
                    e.last      = 1'b1;
                    prod_queue = {prod_queue, e};
                end else begin
                    nr = span(reg_rows);
                    nk = span(reg_inner);
                    nc = span(reg_cols);
                    for (int c = 0; c < nc; c++) begin
                        for (int r = 0; r < nr; r++) begin
                            e.out_row   = DIM_W'(r);
                            e.out_col   = DIM_W'(c);
                            e.out_value = element_sum(r, c, nk);
                            e.last      = (c == nc - 1) && (r == nr - 1);
                            prod_queue = {prod_queue, e};
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Wait before a transaction; now and then a stretch of back-to-back traffic.
    function automatic int draw_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(4, 24);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CFG_W'($urandom_range(9, 15));
            2:       return CFG_W'(MAX_DIM);
            3, 4:    return CFG_W'($urandom_range(4, 7));
            default: return CFG_W'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2:    return $urandom;
            // Small signed Q16.16 values, roughly within plus or minus eight.
            default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        endcase
    endfunction

    // Start stays high into the next transaction when no gap is drawn; the caller
    // lowers it after the last one of a group.
    task automatic send_req(t_in_item it, bit has_exp, logic [VAL_W-1:0] exp_val);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= it;
        do @(posedge i_clk); while (busy);
        apply_item(it, has_exp, exp_val);
        if (it.kind != KIND_NONE) items_sent++;
    endtask

    task automatic send(logic [1:0] kind, int row, int col, logic [VAL_W-1:0] value);
        t_in_item it;
        it.kind  = kind;
        it.row   = DIM_W'(row);
        it.col   = DIM_W'(col);
        it.value = value;
        send_req(it, 1'b0, '0);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_ROWS_A:    reg_rows  = val;
            REG_INNER_DIM: reg_inner = val;
            REG_COLS_B:    reg_cols  = val;
            default: begin
            end
        endcase
    endtask

    task automatic wait_idle();
        while (prod_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        bit prev_cfg;
        int rounds;
        int nr;
        int nk;
        int nc;

        start       <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;

        reg_rows  = DIM_RESET;
        reg_inner = DIM_RESET;
        reg_cols  = DIM_RESET;
        for (int i = 0; i < DEPTH; i++) begin
            mat_a[i]    = '0;
            mat_b[i]    = '0;
            a_loaded[i] = 1'b0;
            b_loaded[i] = 1'b0;
        end

        // One by one products first: zero registers act as one, the spare index does nothing.
        add_cfg(REG_ROWS_A, 4'd0);
        add_cfg(REG_INNER_DIM, 4'd1);
        add_cfg(REG_COLS_B, 4'd0);
        add_cfg(REG_SPARE, 4'hA);
        add_item(KIND_WR_A, 0, 0, 32'h0001_0000, 0, '0);
        add_item(KIND_WR_B, 0, 0, 32'h0002_0000, 0, '0);
        add_item(KIND_COMPUTE, 0, 0, '0, 1, 32'h0002_0000);
        add_item(KIND_WR_A, 0, 0, 32'h7FFF_FFFF, 0, '0);
        add_item(KIND_WR_B, 0, 0, 32'h7FFF_FFFF, 0, '0);
        add_item(KIND_COMPUTE, 7, 7, '1, 1, 32'h7FFF_FFFF);
        add_item(KIND_WR_B, 0, 0, 32'h8000_0000, 0, '0);
        add_item(KIND_COMPUTE, 0, 0, '0, 1, 32'h8000_0000);
        add_item(KIND_WR_A, 0, 0, 32'h8000_0000, 0, '0);
        add_item(KIND_COMPUTE, 0, 0, '0, 1, 32'h7FFF_FFFF);
        // Minus one ulp times one ulp floors to minus one ulp.
        add_item(KIND_WR_A, 0, 0, 32'hFFFF_FFFF, 0, '0);
        add_item(KIND_WR_B, 0, 0, 32'h0000_0001, 0, '0);
        add_item(KIND_COMPUTE, 0, 0, '0, 1, 32'hFFFF_FFFF);
        add_item(KIND_NONE, 7, 7, 32'h1234_5678, 0, '0);
        add_item(KIND_WR_A, 7, 7, 32'h0003_0000, 0, '0);
        add_cfg(REG_ROWS_A, 4'd2);
        add_cfg(REG_INNER_DIM, 4'd2);
        add_cfg(REG_COLS_B, 4'd2);
        add_item(KIND_WR_A, 0, 1, 32'h0001_8000, 0, '0);
        add_item(KIND_WR_A, 1, 0, 32'hFFFE_0000, 0, '0);
        add_item(KIND_WR_A, 1, 1, 32'h0000_4000, 0, '0);
        add_item(KIND_WR_B, 0, 1, 32'h7FFF_FFFF, 0, '0);
        add_item(KIND_WR_B, 1, 0, 32'h0005_0000, 0, '0);
        add_item(KIND_WR_B, 1, 1, 32'h8000_0000, 0, '0);
        add_item(KIND_COMPUTE, 3, 4, 32'h5A5A_A5A5, 0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        prev_cfg = 1'b0;
        foreach (steps[i]) begin
            if (steps[i].is_cfg) begin
                if (!prev_cfg) begin
                    start <= 1'b0;
                    wait_idle();
                end
                cfg_write(steps[i].reg_idx, steps[i].reg_val);
            end else begin
                if (prev_cfg) i_cfg_valid <= 1'b0;
                send_req(steps[i].req, steps[i].has_exp, steps[i].exp_val);
            end
            prev_cfg = steps[i].is_cfg;
        end

        // Random phases: new dimensions, load what the product needs, stir, compute.
        while (items_sent < N_ITEMS) begin
            start <= 1'b0;
            wait_idle();
            cfg_write(REG_ROWS_A, pick_dim());
            cfg_write(REG_INNER_DIM, pick_dim());
            cfg_write(REG_COLS_B, pick_dim());
            if ($urandom_range(0, 3) == 0) cfg_write(REG_SPARE, CFG_W'($urandom_range(0, 15)));
            i_cfg_valid <= 1'b0;
            nr = span(reg_rows);
            nk = span(reg_inner);
            nc = span(reg_cols);
            rounds = $urandom_range(1, 3);
            repeat (rounds) begin
                // Never let the product read an entry that was not loaded.
                for (int r = 0; r < nr; r++) begin
                    for (int k = 0; k < nk; k++) begin
                        if (!a_loaded[r * MAX_DIM + k]) send(KIND_WR_A, r, k, rand_value());
                    end
                end
                for (int k = 0; k < nk; k++) begin
                    for (int c = 0; c < nc; c++) begin
                        if (!b_loaded[k * MAX_DIM + c]) send(KIND_WR_B, k, c, rand_value());
                    end
                end
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 7))
                        0: send(KIND_NONE, $urandom_range(0, 7), $urandom_range(0, 7),
                                rand_value());
                        1: send($urandom_range(0, 1) ? KIND_WR_A : KIND_WR_B,
                                $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
                        default: begin
                            if ($urandom_range(0, 1))
                                send(KIND_WR_A, $urandom_range(0, nr - 1),
                                     $urandom_range(0, nk - 1), rand_value());
                            else
                                send(KIND_WR_B, $urandom_range(0, nk - 1),
                                     $urandom_range(0, nc - 1), rand_value());
                        end
                    endcase
                end
                send(KIND_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
            end
        end

        start <= 1'b0;
        while (prod_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS matrix_multiply");
        end else begin
            $display("FAIL matrix_multiply");
        end
        $finish;
    end

    // Compare every product element with the oldest one predicted.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (prod_queue.size() == 0) begin
                $display("%0t: unexpected transaction row %0d col %0d value %h last %b",
                         $time, o_out.out_row, o_out.out_col, o_out.out_value, o_out.last);
                errors++;
            end else begin
                want = prod_queue.pop_front();
                if (o_out.out_row !== want.out_row) begin
                    $display("%0t: out_row expected %0d got %0d",
                             $time, want.out_row, o_out.out_row);
                    errors++;
                end
                if (o_out.out_col !== want.out_col) begin
                    $display("%0t: out_col expected %0d got %0d",
                             $time, want.out_col, o_out.out_col);
                    errors++;
                end
                if (o_out.out_value !== want.out_value) begin
                    $display("%0t: out_value expected %h got %h",
                             $time, want.out_value, o_out.out_value);
                    errors++;
                end
                if (o_out.last !== want.last) begin
                    $display("%0t: last expected %b got %b", $time, want.last, o_out.last);
                    errors++;
                end
            end
        end
    end

    // Ends the run when no transaction of any kind has happened for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL matrix_multiply");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mm_pkg.sv
hw/rtl/mm_ram.sv
hw/rtl/mm_ctrl.sv
hw/rtl/mm_dp.sv
hw/rtl/matrix_multiply.sv
test/matrix_multiply_tb.sv
